// ===== hdl/cpu6502_execute_unit_defines.svh =====
// Assertion macros shared by the execute unit RTL.
`ifndef CPU6502_EXECUTE_UNIT_DEFINES_SVH
`define CPU6502_EXECUTE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is asserted.
`define CPU65_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define CPU65_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CPU65_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPU65_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/cpu65_pkg.sv =====
// Shared types and constants of the 6502 execute unit.
`default_nettype none

package cpu65_pkg;

	typedef enum logic [5:0] {
		CMD_ADC = 6'd0, CMD_AND, CMD_ASL, CMD_BCC, CMD_BCS, CMD_BEQ, CMD_BMI, CMD_BPL,
		CMD_BVC, CMD_BVS, CMD_BIT, CMD_BNE, CMD_CLC, CMD_CLD, CMD_CLV, CMD_CMP,
		CMD_CPX, CMD_CPY, CMD_DCP, CMD_DEC, CMD_DEX, CMD_DEY, CMD_EOR, CMD_INC,
		CMD_INX, CMD_INY, CMD_ISC, CMD_LAX, CMD_LDA, CMD_LDX, CMD_LDY, CMD_LSR,
		CMD_NOP, CMD_ORA, CMD_PHA, CMD_PHP, CMD_PLA, CMD_PLP, CMD_RLA, CMD_ROL,
		CMD_ROR, CMD_RRA, CMD_SAX, CMD_SBC, CMD_SEC, CMD_SED, CMD_SEI, CMD_SLO,
		CMD_SRE, CMD_STA, CMD_STX, CMD_STY, CMD_TAX, CMD_TAY, CMD_TSX, CMD_TXA,
		CMD_TXS, CMD_TYA
	} cmd_t;

	// Bit positions in the status byte.
	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	localparam logic [7:0]  STACK_PAGE = 8'h01;
	localparam logic [7:0]  PUSH_BITS  = 8'h30;
	localparam logic [7:0]  RESET_P    = 8'h34;
	localparam logic [7:0]  RESET_SP   = 8'hFD;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} arch_t;

	typedef struct packed {
		logic        write_enable;
		logic [15:0] mem_address;
		logic [7:0]  write_data;
		logic        branch_taken;
	} mem_res_t;

endpackage

`default_nettype wire

// ===== hdl/cpu65_req_if.sv =====
// Input channel: one decoded operation per beat.
`default_nettype none

interface cpu65_req_if;
	logic        valid;
	logic        ready;
	logic [5:0]  cmd;
	logic [7:0]  operand;
	logic [15:0] address;
	logic        to_accumulator;

	modport source (output valid, output cmd, output operand, output address,
		output to_accumulator, input ready);
	modport sink (input valid, input cmd, input operand, input address,
		input to_accumulator, output ready);
endinterface

`default_nettype wire

// ===== hdl/cpu65_rsp_if.sv =====
// Result channel: memory write, branch test and register values per beat.
`default_nettype none

interface cpu65_rsp_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [15:0] mem_address;
	logic [7:0]  write_data;
	logic        branch_taken;
	logic [7:0]  acc_out;
	logic [7:0]  x_out;
	logic [7:0]  y_out;
	logic [7:0]  status_out;
	logic [7:0]  sp_out;

	modport source (output valid, output write_enable, output mem_address,
		output write_data, output branch_taken, output acc_out, output x_out,
		output y_out, output status_out, output sp_out, input ready);
	modport sink (input valid, input write_enable, input mem_address,
		input write_data, input branch_taken, input acc_out, input x_out,
		input y_out, input status_out, input sp_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/cpu6502_execute_unit.sv =====
// Top level of the 6502 execute unit: input stage, register file and result register.
// An accepted beat sits in the input register, then executes into the result register.
// Throughput: one operation per cycle while rsp.ready holds; the single execute
// stage between the input and result registers is the only step on the path.
// Reset: A, X and Y clear to zero, SP to 0xFD, P to 0x34, and both stages empty.
`default_nettype none
`include "cpu6502_execute_unit_defines.svh"

module cpu6502_execute_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	cpu65_req_if.sink     req,
	cpu65_rsp_if.source   rsp
);

	logic        valid_s1;
	logic [5:0]  cmd_s1;
	logic [7:0]  operand_s1;
	logic [15:0] address_s1;
	logic        to_acc_s1;

	cpu65_pkg::arch_t    arch_q;
	cpu65_pkg::arch_t    arch_nxt;
	cpu65_pkg::mem_res_t mem_nxt;
	cpu65_pkg::mem_res_t mem_q;
	logic                rsp_valid_q;
	logic                advance;

	// The operation in the input stage executes once the result register is free.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1     <= req.cmd;
			operand_s1 <= req.operand;
			address_s1 <= req.address;
			to_acc_s1  <= req.to_accumulator;
		end
	end

	cpu65_exec u_exec (
		.cmd            (cmd_s1),
		.operand        (operand_s1),
		.address        (address_s1),
		.to_accumulator (to_acc_s1),
		.cur            (arch_q),
		.nxt            (arch_nxt),
		.res            (mem_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q.a    <= 8'd0;
			arch_q.x    <= 8'd0;
			arch_q.y    <= 8'd0;
			arch_q.sp   <= cpu65_pkg::RESET_SP;
			arch_q.p    <= cpu65_pkg::RESET_P;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				arch_q <= arch_nxt;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mem_q <= mem_nxt;
		end
	end

	// The result register shows the registers as they stand after its beat.
	assign rsp.valid        = rsp_valid_q;
	assign rsp.write_enable = mem_q.write_enable;
	assign rsp.mem_address  = mem_q.mem_address;
	assign rsp.write_data   = mem_q.write_data;
	assign rsp.branch_taken = mem_q.branch_taken;
	assign rsp.acc_out      = arch_q.a;
	assign rsp.x_out        = arch_q.x;
	assign rsp.y_out        = arch_q.y;
	assign rsp.status_out   = arch_q.p;
	assign rsp.sp_out       = arch_q.sp;

	`CPU65_ASSERT(a_stall_holds_regs, clk, arst_n, rsp.valid && !rsp.ready |=> $stable(arch_q), "register file changed while the result beat was stalled")
	`CPU65_ASSERT(a_no_write_zero, clk, arst_n, rsp.valid && !rsp.write_enable |-> (rsp.mem_address == 16'd0) && (rsp.write_data == 8'd0), "write fields not zero on a beat without a write")
	`CPU65_ASSERT(a_plp_push_bits, clk, arst_n, advance && (cmd_s1 == cpu65_pkg::CMD_PLP) |=> (arch_q.p[5:4] == 2'b11), "pulled status lost bits 5 and 4")
	`CPU65_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !rsp_valid_q && !valid_s1, "pipeline not empty during reset")

endmodule

`default_nettype wire

// ===== hdl/cpu65_exec.sv =====
// Combinational execute logic: next register state and memory result of one operation.
`default_nettype none

module cpu65_exec (
	input  wire logic [5:0]        cmd,
	input  wire logic [7:0]        operand,
	input  wire logic [15:0]       address,
	input  wire logic              to_accumulator,
	input  wire cpu65_pkg::arch_t  cur,
	output cpu65_pkg::arch_t       nxt,
	output cpu65_pkg::mem_res_t    res
);

	cpu65_pkg::cmd_t cmd_e;
	logic [7:0] src;
	logic [7:0] dec_m;
	logic [7:0] inc_m;
	logic [7:0] rol_m;
	logic [7:0] ror_m;
	logic [7:0] add_m;
	logic       add_ci;
	logic [8:0] sum;
	logic       add_v;
	logic [7:0] cmp_reg;
	logic [7:0] cmp_m;
	logic [8:0] diff;
	logic       old_c;

	assign cmd_e  = cpu65_pkg::cmd_t'(cmd);
	assign old_c  = cur.p[cpu65_pkg::FLAG_C];
	assign src    = to_accumulator ? cur.a : operand;
	assign dec_m  = operand - 8'd1;
	assign inc_m  = operand + 8'd1;
	assign rol_m  = {operand[6:0], old_c};
	assign ror_m  = {old_c, operand[7:1]};

	// One shared adder serves ADC, SBC, ISC and RRA.
	always_comb begin
		case (cmd_e)
			cpu65_pkg::CMD_SBC: add_m = ~operand;
			cpu65_pkg::CMD_ISC: add_m = ~inc_m;
			cpu65_pkg::CMD_RRA: add_m = ror_m;
			default:            add_m = operand;
		endcase
		// RRA adds with the carry its rotate has just produced.
		add_ci = (cmd_e == cpu65_pkg::CMD_RRA) ? operand[0] : old_c;
	end

	assign sum   = {1'b0, cur.a} + {1'b0, add_m} + {8'd0, add_ci};
	assign add_v = (~(cur.a[7] ^ add_m[7])) & (cur.a[7] ^ sum[7]);

	// One shared subtractor serves CMP, CPX, CPY and DCP.
	always_comb begin
		case (cmd_e)
			cpu65_pkg::CMD_CPX: cmp_reg = cur.x;
			cpu65_pkg::CMD_CPY: cmp_reg = cur.y;
			default:            cmp_reg = cur.a;
		endcase
		cmp_m = (cmd_e == cpu65_pkg::CMD_DCP) ? dec_m : operand;
	end

	assign diff = {1'b0, cmp_reg} - {1'b0, cmp_m};

	always_comb begin
		logic [7:0] r;
		logic [7:0] v;
		logic       set_nz;
		nxt    = cur;
		res    = '0;
		r      = '0;
		v      = '0;
		set_nz = 1'b0;
		case (cmd_e)
			cpu65_pkg::CMD_ADC, cpu65_pkg::CMD_SBC: begin
				nxt.a = sum[7:0];
				nxt.p[cpu65_pkg::FLAG_C] = sum[8];
				nxt.p[cpu65_pkg::FLAG_V] = add_v;
				v = sum[7:0];
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_AND: begin
				nxt.a = cur.a & operand;
				v = nxt.a;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_ORA: begin
				nxt.a = cur.a | operand;
				v = nxt.a;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_EOR: begin
				nxt.a = cur.a ^ operand;
				v = nxt.a;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_ASL, cpu65_pkg::CMD_LSR, cpu65_pkg::CMD_ROL,
			cpu65_pkg::CMD_ROR: begin
				case (cmd_e)
					cpu65_pkg::CMD_ASL: begin
						nxt.p[cpu65_pkg::FLAG_C] = src[7];
						r = {src[6:0], 1'b0};
					end
					cpu65_pkg::CMD_LSR: begin
						nxt.p[cpu65_pkg::FLAG_C] = src[0];
						r = {1'b0, src[7:1]};
					end
					cpu65_pkg::CMD_ROL: begin
						nxt.p[cpu65_pkg::FLAG_C] = src[7];
						r = {src[6:0], old_c};
					end
					default: begin
						nxt.p[cpu65_pkg::FLAG_C] = src[0];
						r = {old_c, src[7:1]};
					end
				endcase
				v = r;
				set_nz = 1'b1;
				if (to_accumulator) begin
					nxt.a = r;
				end else begin
					res.write_enable = 1'b1;
					res.mem_address  = address;
					res.write_data   = r;
				end
			end
			cpu65_pkg::CMD_BCC: res.branch_taken = ~cur.p[cpu65_pkg::FLAG_C];
			cpu65_pkg::CMD_BCS: res.branch_taken = cur.p[cpu65_pkg::FLAG_C];
			cpu65_pkg::CMD_BEQ: res.branch_taken = cur.p[cpu65_pkg::FLAG_Z];
			cpu65_pkg::CMD_BNE: res.branch_taken = ~cur.p[cpu65_pkg::FLAG_Z];
			cpu65_pkg::CMD_BMI: res.branch_taken = cur.p[cpu65_pkg::FLAG_N];
			cpu65_pkg::CMD_BPL: res.branch_taken = ~cur.p[cpu65_pkg::FLAG_N];
			cpu65_pkg::CMD_BVC: res.branch_taken = ~cur.p[cpu65_pkg::FLAG_V];
			cpu65_pkg::CMD_BVS: res.branch_taken = cur.p[cpu65_pkg::FLAG_V];
			cpu65_pkg::CMD_BIT: begin
				nxt.p[cpu65_pkg::FLAG_N] = operand[7];
				nxt.p[cpu65_pkg::FLAG_V] = operand[6];
				nxt.p[cpu65_pkg::FLAG_Z] = ((cur.a & operand) == 8'd0);
			end
			cpu65_pkg::CMD_CLC: nxt.p[cpu65_pkg::FLAG_C] = 1'b0;
			cpu65_pkg::CMD_CLD: nxt.p[cpu65_pkg::FLAG_D] = 1'b0;
			cpu65_pkg::CMD_CLV: nxt.p[cpu65_pkg::FLAG_V] = 1'b0;
			cpu65_pkg::CMD_SEC: nxt.p[cpu65_pkg::FLAG_C] = 1'b1;
			cpu65_pkg::CMD_SED: nxt.p[cpu65_pkg::FLAG_D] = 1'b1;
			cpu65_pkg::CMD_SEI: nxt.p[cpu65_pkg::FLAG_I] = 1'b1;
			cpu65_pkg::CMD_CMP, cpu65_pkg::CMD_CPX, cpu65_pkg::CMD_CPY: begin
				v = diff[7:0];
				set_nz = 1'b1;
				nxt.p[cpu65_pkg::FLAG_C] = ~diff[8];
			end
			cpu65_pkg::CMD_DCP: begin
				res.write_enable = 1'b1;
				res.mem_address  = address;
				res.write_data   = dec_m;
				v = diff[7:0];
				set_nz = 1'b1;
				nxt.p[cpu65_pkg::FLAG_C] = ~diff[8];
			end
			cpu65_pkg::CMD_DEC, cpu65_pkg::CMD_INC: begin
				r = (cmd_e == cpu65_pkg::CMD_DEC) ? dec_m : inc_m;
				v = r;
				set_nz = 1'b1;
				res.write_enable = 1'b1;
				res.mem_address  = address;
				res.write_data   = r;
			end
			cpu65_pkg::CMD_DEX: begin
				nxt.x = cur.x - 8'd1;
				v = nxt.x;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_DEY: begin
				nxt.y = cur.y - 8'd1;
				v = nxt.y;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_INX: begin
				nxt.x = cur.x + 8'd1;
				v = nxt.x;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_INY: begin
				nxt.y = cur.y + 8'd1;
				v = nxt.y;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_ISC, cpu65_pkg::CMD_RRA: begin
				if (cmd_e == cpu65_pkg::CMD_ISC) begin
					res.write_data = inc_m;
				end else begin
					res.write_data = ror_m;
				end
				res.write_enable = 1'b1;
				res.mem_address  = address;
				nxt.a = sum[7:0];
				nxt.p[cpu65_pkg::FLAG_C] = sum[8];
				nxt.p[cpu65_pkg::FLAG_V] = add_v;
				v = sum[7:0];
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_LAX: begin
				nxt.a = operand;
				nxt.x = operand;
				v = operand;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_LDA: begin
				nxt.a = operand;
				v = operand;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_LDX: begin
				nxt.x = operand;
				v = operand;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_LDY: begin
				nxt.y = operand;
				v = operand;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_PHA, cpu65_pkg::CMD_PHP: begin
				res.write_enable = 1'b1;
				res.mem_address  = {cpu65_pkg::STACK_PAGE, cur.sp};
				res.write_data   = (cmd_e == cpu65_pkg::CMD_PHA) ? cur.a
					: (cur.p | cpu65_pkg::PUSH_BITS);
				nxt.sp = cur.sp - 8'd1;
			end
			cpu65_pkg::CMD_PLA: begin
				nxt.sp = cur.sp + 8'd1;
				nxt.a = operand;
				v = operand;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_PLP: begin
				nxt.sp = cur.sp + 8'd1;
				nxt.p = operand | cpu65_pkg::PUSH_BITS;
			end
			cpu65_pkg::CMD_RLA: begin
				nxt.p[cpu65_pkg::FLAG_C] = operand[7];
				res.write_enable = 1'b1;
				res.mem_address  = address;
				res.write_data   = rol_m;
				nxt.a = cur.a & rol_m;
				v = nxt.a;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_SLO: begin
				r = {operand[6:0], 1'b0};
				nxt.p[cpu65_pkg::FLAG_C] = operand[7];
				res.write_enable = 1'b1;
				res.mem_address  = address;
				res.write_data   = r;
				nxt.a = cur.a | r;
				v = nxt.a;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_SRE: begin
				r = {1'b0, operand[7:1]};
				nxt.p[cpu65_pkg::FLAG_C] = operand[0];
				res.write_enable = 1'b1;
				res.mem_address  = address;
				res.write_data   = r;
				nxt.a = cur.a ^ r;
				v = nxt.a;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_SAX, cpu65_pkg::CMD_STA, cpu65_pkg::CMD_STX,
			cpu65_pkg::CMD_STY: begin
				res.write_enable = 1'b1;
				res.mem_address  = address;
				case (cmd_e)
					cpu65_pkg::CMD_SAX: res.write_data = cur.a & cur.x;
					cpu65_pkg::CMD_STX: res.write_data = cur.x;
					cpu65_pkg::CMD_STY: res.write_data = cur.y;
					default:            res.write_data = cur.a;
				endcase
			end
			cpu65_pkg::CMD_TAX: begin
				nxt.x = cur.a;
				v = cur.a;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_TAY: begin
				nxt.y = cur.a;
				v = cur.a;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_TSX: begin
				nxt.x = cur.sp;
				v = cur.sp;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_TXA: begin
				nxt.a = cur.x;
				v = cur.x;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_TYA: begin
				nxt.a = cur.y;
				v = cur.y;
				set_nz = 1'b1;
			end
			cpu65_pkg::CMD_TXS: nxt.sp = cur.x;
			default: begin
			end
		endcase
		if (set_nz) begin
			nxt.p[cpu65_pkg::FLAG_N] = v[7];
			nxt.p[cpu65_pkg::FLAG_Z] = (v == 8'd0);
		end
	end

endmodule

`default_nettype wire

// ===== tb/cpu6502_execute_unit_tb.sv =====
// Self-checking testbench of the 6502 execute unit with a built-in register-level predictor.
`timescale 1ns / 1ps

module cpu6502_execute_unit_tb;

	typedef struct {
		logic [5:0]  cmd;
		logic [7:0]  operand;
		logic [15:0] address;
		logic        to_acc;
	} op_item_t;

	typedef struct {
		logic        we;
		logic [15:0] maddr;
		logic [7:0]  wdata;
		logic        br;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  p;
		logic [7:0]  sp;
	} exec_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	cpu65_req_if req_ch();
	cpu65_rsp_if rsp_ch();

	cpu6502_execute_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	op_item_t      op_queue[$];
	exec_outcome_t exec_outcomes[$];
	int            fail_count = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;

	// Architectural registers as the predictor sees them.
	logic [7:0] cpu_a;
	logic [7:0] cpu_x;
	logic [7:0] cpu_y;
	logic [7:0] cpu_sp;
	logic [7:0] cpu_p;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void set_nz(logic [7:0] v);
		cpu_p[cpu65_pkg::FLAG_N] = v[7];
		cpu_p[cpu65_pkg::FLAG_Z] = (v == 8'h00);
	endfunction

	// Binary add with carry into A; subtraction passes the operand inverted.
	function automatic void add_with_carry(logic [7:0] m);
		logic [8:0] sum;
		logic [7:0] r;
		sum = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_p[cpu65_pkg::FLAG_C]};
		r = sum[7:0];
		cpu_p[cpu65_pkg::FLAG_C] = sum[8];
		cpu_p[cpu65_pkg::FLAG_V] = ~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ r[7]);
		set_nz(r);
		cpu_a = r;
	endfunction

	function automatic void compare_reg(logic [7:0] reg_v, logic [7:0] m);
		set_nz(reg_v - m);
		cpu_p[cpu65_pkg::FLAG_C] = (m <= reg_v);
	endfunction

	function automatic exec_outcome_t execute_op(op_item_t op);
		exec_outcome_t o;
		logic          c;
		logic [7:0]    src;
		logic [7:0]    r;
		o = '{default: '0};
		c = cpu_p[cpu65_pkg::FLAG_C];
		src = op.to_acc ? cpu_a : op.operand;
		case (op.cmd)
			cpu65_pkg::CMD_ADC: add_with_carry(op.operand);
			cpu65_pkg::CMD_AND: begin cpu_a = cpu_a & op.operand; set_nz(cpu_a); end
			cpu65_pkg::CMD_ASL, cpu65_pkg::CMD_LSR, cpu65_pkg::CMD_ROL,
			cpu65_pkg::CMD_ROR: begin
				case (op.cmd)
					cpu65_pkg::CMD_ASL: begin
						r = src << 1; cpu_p[cpu65_pkg::FLAG_C] = src[7];
					end
					cpu65_pkg::CMD_LSR: begin
						r = src >> 1; cpu_p[cpu65_pkg::FLAG_C] = src[0];
					end
					cpu65_pkg::CMD_ROL: begin
						r = {src[6:0], c}; cpu_p[cpu65_pkg::FLAG_C] = src[7];
					end
					default: begin
						r = {c, src[7:1]}; cpu_p[cpu65_pkg::FLAG_C] = src[0];
					end
				endcase
				set_nz(r);
				if (op.to_acc) begin
					cpu_a = r;
				end else begin
					o.we = 1'b1; o.maddr = op.address; o.wdata = r;
				end
			end
			cpu65_pkg::CMD_BCC: o.br = !cpu_p[cpu65_pkg::FLAG_C];
			cpu65_pkg::CMD_BCS: o.br = cpu_p[cpu65_pkg::FLAG_C];
			cpu65_pkg::CMD_BEQ: o.br = cpu_p[cpu65_pkg::FLAG_Z];
			cpu65_pkg::CMD_BMI: o.br = cpu_p[cpu65_pkg::FLAG_N];
			cpu65_pkg::CMD_BPL: o.br = !cpu_p[cpu65_pkg::FLAG_N];
			cpu65_pkg::CMD_BVC: o.br = !cpu_p[cpu65_pkg::FLAG_V];
			cpu65_pkg::CMD_BVS: o.br = cpu_p[cpu65_pkg::FLAG_V];
			cpu65_pkg::CMD_BNE: o.br = !cpu_p[cpu65_pkg::FLAG_Z];
			cpu65_pkg::CMD_BIT: begin
				cpu_p[cpu65_pkg::FLAG_N] = op.operand[7];
				cpu_p[cpu65_pkg::FLAG_V] = op.operand[6];
				cpu_p[cpu65_pkg::FLAG_Z] = ((cpu_a & op.operand) == 8'h00);
			end
			cpu65_pkg::CMD_CLC: cpu_p[cpu65_pkg::FLAG_C] = 1'b0;
			cpu65_pkg::CMD_CLD: cpu_p[cpu65_pkg::FLAG_D] = 1'b0;
			cpu65_pkg::CMD_CLV: cpu_p[cpu65_pkg::FLAG_V] = 1'b0;
			cpu65_pkg::CMD_CMP: compare_reg(cpu_a, op.operand);
			cpu65_pkg::CMD_CPX: compare_reg(cpu_x, op.operand);
			cpu65_pkg::CMD_CPY: compare_reg(cpu_y, op.operand);
			cpu65_pkg::CMD_DCP: begin
				r = op.operand - 8'd1;
				o.we = 1'b1; o.maddr = op.address; o.wdata = r;
				compare_reg(cpu_a, r);
			end
			cpu65_pkg::CMD_DEC, cpu65_pkg::CMD_INC: begin
				r = (op.cmd == cpu65_pkg::CMD_DEC) ? op.operand - 8'd1 : op.operand + 8'd1;
				set_nz(r);
				o.we = 1'b1; o.maddr = op.address; o.wdata = r;
			end
			cpu65_pkg::CMD_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
			cpu65_pkg::CMD_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
			cpu65_pkg::CMD_EOR: begin cpu_a = cpu_a ^ op.operand; set_nz(cpu_a); end
			cpu65_pkg::CMD_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
			cpu65_pkg::CMD_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
			cpu65_pkg::CMD_ISC: begin
				r = op.operand + 8'd1;
				o.we = 1'b1; o.maddr = op.address; o.wdata = r;
				add_with_carry(~r);
			end
			cpu65_pkg::CMD_LAX: begin
				cpu_a = op.operand;
				cpu_x = op.operand;
				set_nz(op.operand);
			end
			cpu65_pkg::CMD_LDA: begin cpu_a = op.operand; set_nz(op.operand); end
			cpu65_pkg::CMD_LDX: begin cpu_x = op.operand; set_nz(op.operand); end
			cpu65_pkg::CMD_LDY: begin cpu_y = op.operand; set_nz(op.operand); end
			cpu65_pkg::CMD_ORA: begin cpu_a = cpu_a | op.operand; set_nz(cpu_a); end
			cpu65_pkg::CMD_PHA, cpu65_pkg::CMD_PHP: begin
				o.we = 1'b1;
				o.maddr = {cpu65_pkg::STACK_PAGE, cpu_sp};
				o.wdata = (op.cmd == cpu65_pkg::CMD_PHA) ? cpu_a
					: (cpu_p | cpu65_pkg::PUSH_BITS);
				cpu_sp = cpu_sp - 8'd1;
			end
			cpu65_pkg::CMD_PLA: begin
				cpu_sp = cpu_sp + 8'd1;
				cpu_a = op.operand;
				set_nz(op.operand);
			end
			cpu65_pkg::CMD_PLP: begin
				cpu_sp = cpu_sp + 8'd1;
				cpu_p = op.operand | cpu65_pkg::PUSH_BITS;
			end
			cpu65_pkg::CMD_RLA: begin
				cpu_p[cpu65_pkg::FLAG_C] = op.operand[7];
				r = {op.operand[6:0], c};
				o.we = 1'b1; o.maddr = op.address; o.wdata = r;
				cpu_a = cpu_a & r; set_nz(cpu_a);
			end
			cpu65_pkg::CMD_RRA: begin
				cpu_p[cpu65_pkg::FLAG_C] = op.operand[0];
				r = {c, op.operand[7:1]};
				o.we = 1'b1; o.maddr = op.address; o.wdata = r;
				add_with_carry(r);
			end
			cpu65_pkg::CMD_SAX: begin
				o.we = 1'b1; o.maddr = op.address; o.wdata = cpu_a & cpu_x;
			end
			cpu65_pkg::CMD_SBC: add_with_carry(~op.operand);
			cpu65_pkg::CMD_SEC: cpu_p[cpu65_pkg::FLAG_C] = 1'b1;
			cpu65_pkg::CMD_SED: cpu_p[cpu65_pkg::FLAG_D] = 1'b1;
			cpu65_pkg::CMD_SEI: cpu_p[cpu65_pkg::FLAG_I] = 1'b1;
			cpu65_pkg::CMD_SLO: begin
				cpu_p[cpu65_pkg::FLAG_C] = op.operand[7];
				r = op.operand << 1;
				o.we = 1'b1; o.maddr = op.address; o.wdata = r;
				cpu_a = cpu_a | r; set_nz(cpu_a);
			end
			cpu65_pkg::CMD_SRE: begin
				cpu_p[cpu65_pkg::FLAG_C] = op.operand[0];
				r = op.operand >> 1;
				o.we = 1'b1; o.maddr = op.address; o.wdata = r;
				cpu_a = cpu_a ^ r; set_nz(cpu_a);
			end
			cpu65_pkg::CMD_STA: begin
				o.we = 1'b1; o.maddr = op.address; o.wdata = cpu_a;
			end
			cpu65_pkg::CMD_STX: begin
				o.we = 1'b1; o.maddr = op.address; o.wdata = cpu_x;
			end
			cpu65_pkg::CMD_STY: begin
				o.we = 1'b1; o.maddr = op.address; o.wdata = cpu_y;
			end
			cpu65_pkg::CMD_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
			cpu65_pkg::CMD_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
			cpu65_pkg::CMD_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
			cpu65_pkg::CMD_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
			cpu65_pkg::CMD_TXS: cpu_sp = cpu_x;
			cpu65_pkg::CMD_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
			default: ;
		endcase
		o.a = cpu_a;
		o.x = cpu_x;
		o.y = cpu_y;
		o.p = cpu_p;
		o.sp = cpu_sp;
		return o;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] corner[5];
		corner = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
		if ($urandom_range(99) < 25)
			return corner[$urandom_range(4)];
		return 8'($urandom_range(255));
	endfunction

	function automatic op_item_t random_op();
		op_item_t op;
		if ($urandom_range(99) < 4)
			op.cmd = 6'($urandom_range(63, 58));
		else
			op.cmd = 6'($urandom_range(57));
		op.operand = pick_byte();
		case ($urandom_range(9))
			0: op.address = 16'h0000;
			1: op.address = 16'hFFFF;
			default: op.address = 16'($urandom_range(16'hFFFF));
		endcase
		op.to_acc = 1'($urandom_range(1));
		return op;
	endfunction

	task automatic queue_op(logic [5:0] cmd, logic [7:0] operand, logic [15:0] address,
			logic to_acc);
		op_item_t op;
		op.cmd = cmd;
		op.operand = operand;
		op.address = address;
		op.to_acc = to_acc;
		op_queue.push_back(op);
	endtask

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Operation driver: predicts each accepted beat, then offers the next one.
	always @(posedge clk) begin
		op_item_t nxt;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				exec_outcomes.push_back(execute_op('{req_ch.cmd, req_ch.operand,
					req_ch.address, req_ch.to_accumulator}));
			if (!req_ch.valid || req_ch.ready) begin
				if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = op_queue.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.cmd <= nxt.cmd;
					req_ch.operand <= nxt.operand;
					req_ch.address <= nxt.address;
					req_ch.to_accumulator <= nxt.to_acc;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk) begin
		exec_outcome_t exp_o;
		if (arst_n) begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (exec_outcomes.size() == 0) begin
					$error("result beat with no operation outstanding");
					fail_count++;
				end else begin
					exp_o = exec_outcomes.pop_front();
					check_field("write_enable", exp_o.we, rsp_ch.write_enable);
					check_field("mem_address", exp_o.maddr, rsp_ch.mem_address);
					check_field("write_data", exp_o.wdata, rsp_ch.write_data);
					check_field("branch_taken", exp_o.br, rsp_ch.branch_taken);
					check_field("acc_out", exp_o.a, rsp_ch.acc_out);
					check_field("x_out", exp_o.x, rsp_ch.x_out);
					check_field("y_out", exp_o.y, rsp_ch.y_out);
					check_field("status_out", exp_o.p, rsp_ch.status_out);
					check_field("sp_out", exp_o.sp, rsp_ch.sp_out);
				end
			end
		end
	end

	initial begin
		// Driven after every process has started, so the falling edge resets the design.
		arst_n <= 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.operand = '0;
		req_ch.address = '0;
		req_ch.to_accumulator = 1'b0;
		rsp_ch.ready = 1'b0;
		cpu_a = 8'h00;
		cpu_x = 8'h00;
		cpu_y = 8'h00;
		cpu_sp = cpu65_pkg::RESET_SP;
		cpu_p = cpu65_pkg::RESET_P;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct <= 24; recv_idle_pct <= 52; end
				1: begin send_idle_pct <= 52; recv_idle_pct <= 24; end
				default: begin send_idle_pct <= 0; recv_idle_pct <= 0; end
			endcase
			if (phase == 0) begin
				// Signed overflow, carry out, and the decimal flag having no effect.
				queue_op(cpu65_pkg::CMD_LDA, 8'h7F, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_ADC, 8'h01, 16'hFFFF, 1'b1);
				queue_op(cpu65_pkg::CMD_ADC, 8'hFF, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_SBC, 8'h80, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_CMP, 8'hFF, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_SED, 8'h00, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_ADC, 8'h09, 16'h0000, 1'b0);
				// Shifts on the accumulator and on memory; stores ignore the mode bit.
				queue_op(cpu65_pkg::CMD_ASL, 8'h00, 16'hFFFF, 1'b1);
				queue_op(cpu65_pkg::CMD_ROR, 8'h01, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_ROL, 8'hFF, 16'h1234, 1'b1);
				queue_op(cpu65_pkg::CMD_LSR, 8'hFF, 16'hFFFF, 1'b0);
				queue_op(cpu65_pkg::CMD_STA, 8'h00, 16'hFFFF, 1'b1);
				// Stack pointer wrap in both directions and the pushed status bits.
				queue_op(cpu65_pkg::CMD_LDX, 8'h00, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_TXS, 8'h00, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_PHA, 8'h00, 16'hFFFF, 1'b0);
				queue_op(cpu65_pkg::CMD_PHP, 8'h00, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_PLP, 8'h00, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_PLA, 8'h80, 16'h0000, 1'b0);
				// Decrement of Y down to zero, then BIT and the branches on N and V.
				queue_op(cpu65_pkg::CMD_LDY, 8'h01, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_DEY, 8'h00, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_BIT, 8'hC0, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_BMI, 8'h00, 16'h0000, 1'b0);
				queue_op(cpu65_pkg::CMD_BVS, 8'h00, 16'h0000, 1'b0);
				// Selectors past the last operation behave as no-ops.
				queue_op(6'd63, 8'hFF, 16'hFFFF, 1'b1);
				queue_op(6'd58, 8'h00, 16'h0000, 1'b0);
			end
			repeat (530) op_queue.push_back(random_op());
			while (op_queue.size() != 0 || req_ch.valid) @(posedge clk);
		end

		while (exec_outcomes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== cpu6502_execute_unit.f =====
+incdir+hdl
hdl/cpu65_pkg.sv
hdl/cpu65_req_if.sv
hdl/cpu65_rsp_if.sv
hdl/cpu65_exec.sv
hdl/cpu6502_execute_unit.sv
tb/cpu6502_execute_unit_tb.sv
